FILE: hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk with rst_n as the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/dfip_pkg.sv
package dfip_pkg;

  // link control bytes
  localparam logic [7:0] DleByte = 8'h10;
  localparam logic [7:0] StxByte = 8'h02;
  localparam logic [7:0] EtxByte = 8'h03;

  // payload layout
  localparam int StatusPos  = 0;
  localparam int PairBase   = 7;
  localparam int NumVals    = 6;
  localparam int MinPayload = 19;

  // per-request events from the unstuffer
  typedef struct packed {
    logic store_en;    // payload byte goes into the frame store
    logic frame_end;   // DLE ETX seen, a result is due
    logic short_frame; // frame ended with too few bytes
    logic overrun;     // bytes were dropped in this frame
  } dfip_evt_t;

endpackage

FILE: hw/rtl/dfip_unstuff.sv
module dfip_unstuff import dfip_pkg::*; #(
  parameter int FRAME_BYTES = 32,
  localparam int CNT_W = $clog2(FRAME_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output dfip_evt_t        evt,
  output logic [CNT_W-1:0] byte_count
);

  localparam logic [1:0] ModeHunt     = 2'd0;
  localparam logic [1:0] ModeHuntDle  = 2'd1;
  localparam logic [1:0] ModeFrame    = 2'd2;
  localparam logic [1:0] ModeFrameDle = 2'd3;

  logic [1:0]       mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovr_r, ovr_nxt;
  logic             put;
  logic             room;

  assign room = (cnt_r < CNT_W'(FRAME_BYTES));

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    ovr_nxt  = ovr_r;
    put      = 1'b0;
    evt      = '0;
    case (mode_r)
      ModeHunt: begin
        if (rx_byte == DleByte) mode_nxt = ModeHuntDle;
      end
      ModeHuntDle: begin
        if (rx_byte == StxByte) begin
          mode_nxt = ModeFrame;
          cnt_nxt  = '0;
          ovr_nxt  = 1'b0;
        end else begin
          mode_nxt = ModeHunt;
        end
      end
      ModeFrame: begin
        if (rx_byte == DleByte) mode_nxt = ModeFrameDle;
        else                    put      = 1'b1;
      end
      ModeFrameDle: begin
        if (rx_byte == DleByte) begin
          put      = 1'b1;
          mode_nxt = ModeFrame;
        end else begin
          // ETX closes the frame; any other pair aborts it
          mode_nxt        = ModeHunt;
          evt.frame_end   = (rx_byte == EtxByte);
          evt.short_frame = (cnt_r < CNT_W'(MinPayload));
          evt.overrun     = ovr_r;
        end
      end
      default: mode_nxt = ModeHunt;
    endcase
    if (put) begin
      if (room) begin
        evt.store_en = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
      end else begin
        ovr_nxt = 1'b1;
      end
    end
    evt.store_en  = evt.store_en & accept;
    evt.frame_end = evt.frame_end & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeHunt;
      cnt_r  <= '0;
      ovr_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      ovr_r  <= ovr_nxt;
    end
  end

  assign byte_count = cnt_r;

endmodule

FILE: hw/rtl/dfip_capture.sv
module dfip_capture import dfip_pkg::*; #(
  parameter int FRAME_BYTES = 32,
  localparam int CNT_W = $clog2(FRAME_BYTES + 1)
) (
  input  logic                     clk,
  input  dfip_evt_t                evt,
  input  logic [CNT_W-1:0]         wr_idx,
  input  logic [7:0]               wr_byte,
  output logic [7:0]               status_byte,
  output logic [NumVals-1:0][15:0] vals
);

  // Only the bytes that the result uses are kept.
  logic [7:0] status_r;
  logic [7:0] hi_r [NumVals];
  logic [7:0] lo_r [NumVals];

  always_ff @(posedge clk) begin
    if (evt.store_en && wr_idx == CNT_W'(StatusPos)) status_r <= wr_byte;
    for (int k = 0; k < NumVals; k++) begin
      if (evt.store_en && wr_idx == CNT_W'(PairBase + 2 * k))     hi_r[k] <= wr_byte;
      if (evt.store_en && wr_idx == CNT_W'(PairBase + 2 * k + 1)) lo_r[k] <= wr_byte;
    end
  end

  // ((hi << 7) | (lo >> 1)) << 1 on 16 bits; zeroed for a short frame
  always_comb begin
    status_byte = evt.short_frame ? 8'h00 : status_r;
    for (int k = 0; k < NumVals; k++) begin
      vals[k] = evt.short_frame ? 16'h0000 : {hi_r[k], lo_r[k][7:1], 1'b0};
    end
  end

endmodule

FILE: hw/rtl/dle_framed_imu_packet_decoder_top.sv
// Channel  | Ports                                   | Moves
// ---------+-----------------------------------------+------------------------------
// input    | in_valid, in_stall, in_rx_byte          | one received byte per request
// result   | out_valid, out_stall, out_status_byte,  | one decoded frame per request
//          | out_rate_*, out_accel_*, out_short_frame,|
//          | out_overrun                             |
//
// One byte is taken every cycle unless in_stall holds it off; the unstuffer and byte
// capture settle combinationally between the link state and the result register.
// A result appears on out_valid the cycle after its DLE ETX byte is taken.
// rst_n is synchronous: the link returns to hunting and the result register empties.
// in_stall rises only while a result sits in the output register and out_stall holds it.
`include "assert_macros.svh"

module dle_framed_imu_packet_decoder_top import dfip_pkg::*; #(
  parameter int FRAME_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_status_byte,
  output logic signed [15:0] out_rate_roll,
  output logic signed [15:0] out_rate_pitch,
  output logic signed [15:0] out_rate_yaw,
  output logic signed [15:0] out_accel_surge,
  output logic signed [15:0] out_accel_sway,
  output logic signed [15:0] out_accel_heave,
  output logic               out_short_frame,
  output logic               out_overrun
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  logic                     in_accept;
  dfip_evt_t                evt;
  logic [CNT_W-1:0]         byte_count;
  logic [7:0]               status_byte;
  logic [NumVals-1:0][15:0] vals;

  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               status_r;
  logic [NumVals-1:0][15:0] vals_r;
  logic                     short_r;
  logic                     ovr_r;
  logic                     short_zero;

  // hold off only while a finished result is blocked
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  dfip_unstuff #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_unstuff (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .rx_byte    (in_rx_byte),
    .evt        (evt),
    .byte_count (byte_count)
  );

  // captured bytes are written at the store index before it advances
  dfip_capture #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_capture (
    .clk         (clk),
    .evt         (evt),
    .wr_idx      (byte_count),
    .wr_byte     (in_rx_byte),
    .status_byte (status_byte),
    .vals        (vals)
  );

  // result register: filled at frame end, emptied when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (evt.frame_end)   out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (evt.frame_end) begin
      status_r <= status_byte;
      vals_r   <= vals;
      short_r  <= evt.short_frame;
      ovr_r    <= evt.overrun;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status_byte = status_r;
  assign out_rate_roll   = $signed(vals_r[0]);
  assign out_rate_pitch  = $signed(vals_r[1]);
  assign out_rate_yaw    = $signed(vals_r[2]);
  assign out_accel_surge = $signed(vals_r[3]);
  assign out_accel_sway  = $signed(vals_r[4]);
  assign out_accel_heave = $signed(vals_r[5]);
  assign out_short_frame = short_r;
  assign out_overrun     = ovr_r;

  // every data field of the held result is zero
  assign short_zero = (status_r == 8'h00) && (vals_r == '0);

  // a closed frame always lands in the result register
  `ASSERT_RUN(a_end_gives_result, evt.frame_end |=> out_valid_r, "frame end lost")
  // short frames carry zeroed data
  `ASSERT_RUN(a_short_zero, (out_valid_r && out_short_frame) |-> short_zero, "short frame data")
  // store index never passes the store size
  `ASSERT_RUN(a_count_bound, byte_count <= CNT_W'(FRAME_BYTES), "byte count past store")
  // reset empties the result register
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
